### hw/rtl/rpsd_pkg.sv
// ----------------------------------------------------------------------------
// rpsd_pkg
// shared types and constants of the rle pixel stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rpsd_pkg;

  localparam int unsigned WORD_W           = 16;
  localparam int unsigned LEN_W            = 15;
  localparam int unsigned TOTAL_PIXELS_W   = 20;
  localparam int unsigned CFG_INDEX_W      = 2;
  localparam int unsigned CFG_DATA_W       = 20;
  localparam int unsigned PIXEL_COUNT_BITS_DEF = 20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOTAL_PIXELS        = 2'd0,
    REG_KEY_COLOR           = 2'd1,
    REG_BACKGROUND_COLOR    = 2'd2,
    REG_TRANSPARENCY_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] stream_word;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] pixel_color;
    logic [LEN_W-1:0]  repeat_length;
    logic              image_done;
  } out_item_t;

  typedef struct packed {
    logic [TOTAL_PIXELS_W-1:0] total_pixels;
    logic [WORD_W-1:0]         key_color;
    logic [WORD_W-1:0]         background_color;
    logic                      transparency_enable;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/rpsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpsd_cfg_regs
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
`default_nettype none

module rpsd_cfg_regs
  import rpsd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOTAL_PIXELS: begin
          cfg_r.total_pixels <= cfg_data[TOTAL_PIXELS_W-1:0];
        end
        REG_KEY_COLOR: begin
          cfg_r.key_color <= cfg_data[WORD_W-1:0];
        end
        REG_BACKGROUND_COLOR: begin
          cfg_r.background_color <= cfg_data[WORD_W-1:0];
        end
        REG_TRANSPARENCY_ENABLE: begin
          cfg_r.transparency_enable <= cfg_data[0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rpsd_in_stage.sv
// ----------------------------------------------------------------------------
// rpsd_in_stage
// input register holding one stream item ahead of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

module rpsd_in_stage
  import rpsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  wire logic advance,
  output logic      item_vld,
  output in_item_t  item
);

  logic     vld_r;
  in_item_t item_r;

  assign in_stall = vld_r && !advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
      if (in_valid) begin
        item_r <= in_data;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rpsd_decoder.sv
// ----------------------------------------------------------------------------
// rpsd_decoder
// run state, pixel count and result register of the rle decoder
// ----------------------------------------------------------------------------
`default_nettype none

module rpsd_decoder
  import rpsd_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic item_vld,
  input  in_item_t  item,
  output logic      advance,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int unsigned CW = (PIXEL_COUNT_BITS > LEN_W) ? PIXEL_COUNT_BITS : LEN_W;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_t;

  mode_t                       mode_r, mode_nxt, mode_e;
  logic [LEN_W-1:0]            lit_r, lit_nxt, lit_e;
  logic [LEN_W-1:0]            rep_r, rep_nxt, rep_e;
  logic [PIXEL_COUNT_BITS-1:0] pix_r, pix_nxt, pix_e;
  logic                        fin_r, fin_nxt, fin_e;
  logic                        out_valid_r;
  out_item_t                   out_data_r, out_data_nxt;

  logic [PIXEL_COUNT_BITS-1:0] total;
  logic [PIXEL_COUNT_BITS-1:0] remaining;
  logic [PIXEL_COUNT_BITS-1:0] pix_sum;
  logic [CW-1:0]               len;
  logic [WORD_W-1:0]           neg_word;
  logic                        has_res;
  logic                        proceed;
  logic [WORD_W-1:0]           word;

  generate
    if (PIXEL_COUNT_BITS >= TOTAL_PIXELS_W) begin : g_total_ext
      assign total = PIXEL_COUNT_BITS'(cfg.total_pixels);
    end else begin : g_total_cut
      assign total = cfg.total_pixels[PIXEL_COUNT_BITS-1:0];
    end
  endgenerate

  assign advance   = !out_valid_r || !out_stall;
  assign proceed   = item_vld && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign word      = item.stream_word;

  always_comb begin
    if (item.restart) begin
      mode_e = MODE_HEADER;
      lit_e  = '0;
      rep_e  = '0;
      pix_e  = '0;
      fin_e  = 1'b0;
    end else begin
      mode_e = mode_r;
      lit_e  = lit_r;
      rep_e  = rep_r;
      pix_e  = pix_r;
      fin_e  = fin_r;
    end

    mode_nxt  = mode_e;
    lit_nxt   = lit_e;
    rep_nxt   = rep_e;
    pix_nxt   = pix_e;
    fin_nxt   = fin_e;
    has_res   = 1'b0;
    len       = CW'(1);
    remaining = total - pix_e;
    neg_word  = WORD_W'(0) - word;
    pix_sum   = '0;

    if (fin_e) begin
      has_res = 1'b0;
    end else if (pix_e >= total) begin
      fin_nxt  = 1'b1;
      mode_nxt = MODE_HEADER;
    end else begin
      case (mode_e)
        MODE_LITERAL: begin
          has_res = 1'b1;
          len     = CW'(1);
          lit_nxt = lit_e - LEN_W'(1);
          if (lit_nxt == '0) begin
            mode_nxt = MODE_HEADER;
          end
        end
        MODE_REPEAT: begin
          has_res  = 1'b1;
          len      = (CW'(rep_e) > CW'(remaining)) ? CW'(remaining) : CW'(rep_e);
          mode_nxt = MODE_HEADER;
          rep_nxt  = '0;
        end
        default: begin
          if (word[WORD_W-1]) begin
            lit_nxt  = neg_word[WORD_W-1] ? {LEN_W{1'b1}} : neg_word[LEN_W-1:0];
            mode_nxt = MODE_LITERAL;
          end else if (word != '0) begin
            rep_nxt  = word[LEN_W-1:0];
            mode_nxt = MODE_REPEAT;
          end
        end
      endcase
      if (has_res) begin
        pix_sum = pix_e + len[PIXEL_COUNT_BITS-1:0];
        pix_nxt = pix_sum;
        if (pix_sum >= total) begin
          fin_nxt  = 1'b1;
          mode_nxt = MODE_HEADER;
          lit_nxt  = '0;
          rep_nxt  = '0;
        end
      end
    end

    out_data_nxt.pixel_color   = (cfg.transparency_enable && word == cfg.key_color)
                                 ? cfg.background_color : word;
    out_data_nxt.repeat_length = len[LEN_W-1:0];
    out_data_nxt.image_done    = has_res && (pix_sum >= total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_HEADER;
      lit_r       <= '0;
      rep_r       <= '0;
      pix_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= proceed && has_res;
      end
      if (proceed) begin
        mode_r <= mode_nxt;
        lit_r  <= lit_nxt;
        rep_r  <= rep_nxt;
        pix_r  <= pix_nxt;
        fin_r  <= fin_nxt;
        if (has_res) begin
          out_data_r <= out_data_nxt;
        end
      end
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> mode_r == MODE_HEADER)
    else $error("finished decoder left in a run");

  a_lit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_LITERAL |-> lit_r != '0)
    else $error("literal run with nothing left");

  a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.image_done |-> fin_r)
    else $error("image done shown but decoder not finished");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.repeat_length != '0)
    else $error("zero-length run item");

endmodule

`default_nettype wire

### hw/rtl/rle_pixel_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_pixel_stream_decoder_unit
// run-length decoder for a 16-bit rgb565 image stream
//
// in_*  : stream words with a restart flag, valid/stall handshake
// out_* : one run item per pixel word (colour, repeat length, image done)
// cfg_* : register writes (total pixels, transparent and background colour,
//         transparency enable), always ready; write only while idle
// a header word gives no item; a negative header opens a literal run, a
// positive one a repeat of the next word, clipped to the pixels left
// out_valid is registered: an accepted word goes through the input register
// and then the result register before its item is shown
// throughput: one word per cycle while out_stall holds no pending item
// when out_stall holds a pending item, the input register fills and then
// in_stall rises; nothing is dropped
// reset (rst_n low at a clock edge) clears the registers, the run state,
// the pixel count and both pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none

module rle_pixel_stream_decoder_unit
  import rpsd_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  in_item_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  logic     advance;
  logic     item_vld;
  in_item_t item;

  rpsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpsd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  rpsd_decoder #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_vld  (item_vld),
    .item      (item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
